/* src/tir_pkg.sv */
`timescale 1ns / 1ps
package tir_pkg;

  localparam int TYPE_W       = 5;
  localparam int CODE_W       = 10;
  localparam int VALUE_W      = 32;
  localparam int COORD_W      = 26;
  localparam int QUOT_W       = 25;
  localparam int MAP_W        = 32;
  localparam int SLOTS_DEFAULT = 32;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 26;

  // Event type and code values
  localparam logic [TYPE_W-1:0] TYPE_ABS   = 5'd3;
  localparam logic [CODE_W-1:0] CODE_SYNC  = 10'd0;
  localparam logic [CODE_W-1:0] CODE_SLOT  = 10'd47;
  localparam logic [CODE_W-1:0] CODE_X     = 10'd53;
  localparam logic [CODE_W-1:0] CODE_Y     = 10'd54;
  localparam logic [CODE_W-1:0] CODE_TRACK = 10'd57;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TOP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BOTTOM = 3'd4;

  // n / 100 == (n * DIV_MAGIC) >> DIV_SHIFT for any 32-bit unsigned n
  localparam logic [31:0] DIV_MAGIC = 32'd1374389535;
  localparam int          DIV_SHIFT = 37;

  typedef enum logic [1:0] {
    CLS_OTHER = 2'd0,
    CLS_POS   = 2'd1,
    CLS_NONE  = 2'd2
  } id_class_t;

  typedef struct packed {
    logic                      enable;
    logic signed [COORD_W-1:0] left_bound;
    logic signed [COORD_W-1:0] top_bound;
    logic signed [COORD_W-1:0] right_bound;
    logic signed [COORD_W-1:0] bottom_bound;
  } tir_cfg_t;

  typedef struct packed {
    logic [TYPE_W-1:0]         event_type;
    logic [CODE_W-1:0]         event_code;
    logic signed [VALUE_W-1:0] event_value;
    logic [QUOT_W-1:0]         quot_mag;
    logic                      quot_neg;
  } tir_stage_t;

  typedef struct packed {
    logic             region_level;
    logic             level_changed;
    logic [MAP_W-1:0] active_map;
  } tir_res_t;

endpackage

/* src/tir_event_if.sv */
`timescale 1ns / 1ps
interface tir_event_if;
  logic                               valid;
  logic                               ready;
  logic [tir_pkg::TYPE_W-1:0]         event_type;
  logic [tir_pkg::CODE_W-1:0]         event_code;
  logic signed [tir_pkg::VALUE_W-1:0] event_value;

  modport source (output valid, event_type, event_code, event_value, input ready);
  modport sink   (input valid, event_type, event_code, event_value, output ready);
endinterface

/* src/tir_result_if.sv */
`timescale 1ns / 1ps
interface tir_result_if;
  logic                       valid;
  logic                       ready;
  logic                       region_level;
  logic                       level_changed;
  logic [tir_pkg::MAP_W-1:0]  active_map;

  modport source (output valid, region_level, level_changed, active_map, input ready);
  modport sink   (input valid, region_level, level_changed, active_map, output ready);
endinterface

/* src/touch_in_region_slot_tracker.sv */
`timescale 1ns / 1ps
// Channel   Dir  Payload                                    Handshake
// events    in   event_type, event_code, event_value        valid / ready
// results   out  region_level, level_changed, active_map    valid / ready
// cfg       in   cfg_index, cfg_data                        cfg_we, no wait
//
// One request in, one result out, one request per cycle sustained unless results stall.
// The divide-by-100 multiplier feeds the input stage register, then the slot
// update and rectangle compares feed the result register.
// Reset (rst, synchronous) clears the slot tables, the active map, the drive
// level, the configuration registers and both valid flags.
// A stalled result holds; the input stage still takes one more request behind it.
module touch_in_region_slot_tracker #(
  parameter int SLOTS = tir_pkg::SLOTS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  tir_event_if.sink                         events,
  tir_result_if.source                      results,
  input  logic                              cfg_we,
  input  logic [tir_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tir_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import tir_pkg::*;

  tir_cfg_t   cfg;
  tir_stage_t stage;
  tir_res_t   res_next;
  tir_res_t   res;
  logic       stage_valid;
  logic       res_valid;
  logic       advance;
  logic       stage_fire;
  logic       in_fire;

  // Move the input stage on when the result register is empty or being drained
  assign advance    = !res_valid || results.ready;
  assign stage_fire = stage_valid && advance;
  assign events.ready = !stage_valid || advance;
  assign in_fire    = events.valid && events.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      res_valid   <= 1'b0;
    end else begin
      if (in_fire) begin
        stage_valid <= 1'b1;
      end else if (stage_fire) begin
        stage_valid <= 1'b0;
      end
      if (stage_fire) begin
        res_valid <= 1'b1;
      end else if (results.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Configuration registers; unknown indexes drop the write
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ENABLE: cfg.enable       <= cfg_data[0];
        REG_LEFT:   cfg.left_bound   <= $signed(cfg_data);
        REG_TOP:    cfg.top_bound    <= $signed(cfg_data);
        REG_RIGHT:  cfg.right_bound  <= $signed(cfg_data);
        REG_BOTTOM: cfg.bottom_bound <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // Input stage: latch the request and the scaled coordinate magnitude
  tir_scale u_scale (
    .clk         (clk),
    .load        (in_fire),
    .event_type  (events.event_type),
    .event_code  (events.event_code),
    .event_value (events.event_value),
    .stage       (stage)
  );

  // Slot state; commits exactly once per request as it enters the result register
  tir_track #(
    .SLOTS (SLOTS)
  ) u_track (
    .clk      (clk),
    .rst      (rst),
    .commit   (stage_fire),
    .stage    (stage),
    .cfg      (cfg),
    .res_next (res_next)
  );

  always_ff @(posedge clk) begin
    if (stage_fire) begin
      res <= res_next;
    end
  end

  assign results.valid         = res_valid;
  assign results.region_level  = res.region_level;
  assign results.level_changed = res.level_changed;
  assign results.active_map    = res.active_map;
endmodule

/* src/tir_scale.sv */
`timescale 1ns / 1ps
module tir_scale (
  input  logic                               clk,
  input  logic                               load,
  input  logic [tir_pkg::TYPE_W-1:0]         event_type,
  input  logic [tir_pkg::CODE_W-1:0]         event_code,
  input  logic signed [tir_pkg::VALUE_W-1:0] event_value,
  output tir_pkg::tir_stage_t                stage
);
  import tir_pkg::*;

  logic [VALUE_W-1:0]   mag;
  logic [2*VALUE_W-1:0] prod;

  // Divide the magnitude by the scale; sign is put back downstream
  assign mag  = event_value[VALUE_W-1] ? (~event_value + 32'd1) : event_value;
  assign prod = {32'd0, mag} * {32'd0, DIV_MAGIC};

  always_ff @(posedge clk) begin
    if (load) begin
      stage.event_type  <= event_type;
      stage.event_code  <= event_code;
      stage.event_value <= event_value;
      stage.quot_mag    <= prod[DIV_SHIFT +: QUOT_W];
      stage.quot_neg    <= event_value[VALUE_W-1];
    end
  end
endmodule

/* src/tir_track.sv */
`timescale 1ns / 1ps
module tir_track #(
  parameter int SLOTS = tir_pkg::SLOTS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                commit,
  input  tir_pkg::tir_stage_t stage,
  input  tir_pkg::tir_cfg_t   cfg,
  output tir_pkg::tir_res_t   res_next
);
  import tir_pkg::*;

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [SLOT_W-1:0]         current_slot;
  logic signed [COORD_W-1:0] slot_x [SLOTS];
  logic signed [COORD_W-1:0] slot_y [SLOTS];
  id_class_t                 slot_cls [SLOTS];
  logic [MAP_W-1:0]          slot_active;
  logic                      drive_level;

  logic signed [COORD_W-1:0] coord;
  logic                      is_abs;
  logic                      slot_ok;
  id_class_t                 cls_new;
  id_class_t                 cls_eval;
  logic signed [COORD_W-1:0] x_cur;
  logic signed [COORD_W-1:0] y_cur;
  logic                      in_rect;
  logic [MAP_W-1:0]          slot_sel;
  logic [MAP_W-1:0]          slot_active_next;
  logic                      drive_level_next;

  assign coord = stage.quot_neg ? -$signed({1'b0, stage.quot_mag})
                                :  $signed({1'b0, stage.quot_mag});
  assign is_abs  = (stage.event_type == TYPE_ABS);
  assign slot_ok = !stage.event_value[VALUE_W-1] &&
                   (stage.event_value < VALUE_W'(SLOTS));

  always_comb begin
    if (stage.event_value == -32'sd1) begin
      cls_new = CLS_NONE;
    end else if (stage.event_value > 32'sd0) begin
      cls_new = CLS_POS;
    end else begin
      cls_new = CLS_OTHER;
    end
  end

  // Bypass the class written by this same tracking event
  assign cls_eval = (is_abs && stage.event_code == CODE_TRACK) ? cls_new
                                                               : slot_cls[current_slot];
  assign x_cur    = slot_x[current_slot];
  assign y_cur    = slot_y[current_slot];
  assign in_rect  = (x_cur > cfg.left_bound) && (x_cur < cfg.right_bound) &&
                    (y_cur > cfg.top_bound)  && (y_cur < cfg.bottom_bound);
  assign slot_sel = MAP_W'(1) << current_slot;

  always_comb begin
    slot_active_next = slot_active;
    drive_level_next = drive_level;
    if (cfg.enable && stage.event_code == CODE_TRACK) begin
      if (cls_eval == CLS_NONE) begin
        slot_active_next = slot_active & ~slot_sel;
      end
    end else if (cfg.enable && stage.event_code == CODE_SYNC) begin
      if (cls_eval == CLS_POS) begin
        slot_active_next = in_rect ? (slot_active | slot_sel) : (slot_active & ~slot_sel);
      end
      drive_level_next = |slot_active_next;
    end
  end

  assign res_next.region_level  = drive_level_next;
  assign res_next.level_changed = drive_level_next ^ drive_level;
  assign res_next.active_map    = slot_active_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      current_slot <= '0;
      slot_active  <= '0;
      drive_level  <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        slot_x[i]   <= '0;
        slot_y[i]   <= '0;
        slot_cls[i] <= CLS_OTHER;
      end
    end else if (commit) begin
      slot_active <= slot_active_next;
      drive_level <= drive_level_next;
      if (is_abs) begin
        case (stage.event_code)
          CODE_SLOT: begin
            if (slot_ok) begin
              current_slot <= stage.event_value[SLOT_W-1:0];
            end
          end
          CODE_X:     slot_x[current_slot]   <= coord;
          CODE_Y:     slot_y[current_slot]   <= coord;
          CODE_TRACK: slot_cls[current_slot] <= cls_new;
          default: ;
        endcase
      end
    end
  end
endmodule

/* src/tir_checker.sv */
`timescale 1ns / 1ps
module tir_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      res_valid,
  input logic                      res_ready,
  input logic                      region_level,
  input logic                      level_changed,
  input logic [tir_pkg::MAP_W-1:0] active_map
);
  import tir_pkg::*;

  logic last_level;

  // Track the level of the last delivered result
  always_ff @(posedge clk) begin
    if (rst) begin
      last_level <= 1'b0;
    end else if (res_valid && res_ready) begin
      last_level <= region_level;
    end
  end

  a_reset_idle: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(region_level) &&
      $stable(level_changed) && $stable(active_map))
    else $error("stalled result changed");

  a_low_level_empty_map: assert property (@(posedge clk) disable iff (rst)
    res_valid && !region_level |-> active_map == '0)
    else $error("active map set while level is low");

  a_change_flag: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> level_changed == (region_level != last_level))
    else $error("level change flag disagrees with level history");
endmodule

bind touch_in_region_slot_tracker tir_checker u_tir_checker (
  .clk           (clk),
  .rst           (rst),
  .res_valid     (results.valid),
  .res_ready     (results.ready),
  .region_level  (results.region_level),
  .level_changed (results.level_changed),
  .active_map    (results.active_map)
);

/* bench/touch_in_region_slot_tracker_test.sv */
`timescale 1ns / 1ps

module touch_in_region_slot_tracker_test;
  import tir_pkg::*;

  localparam int SLOT_COUNT   = SLOTS_DEFAULT;
  localparam int COORD_SCALE  = 100;
  localparam int RANDOM_ITEMS = 1420;
  localparam int PHASES       = 8;
  localparam int HOLD_CYCLES  = 60;
  localparam int DRAIN_CYCLES = 8;
  localparam int BOUND_LIMIT  = 21474837;
  localparam int FIELD_MIN    = -(1 << (COORD_W - 1));
  localparam int FIELD_MAX    = (1 << (COORD_W - 1)) - 1;

  // Sync reports arrive with event type zero.
  localparam logic [TYPE_W-1:0] TYPE_SYN_EVENT = 5'd0;
  // Indexes past the last register; writes there must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  // Tracking id that lifts a touch.
  localparam int ID_LIFT = -1;

  // Predict the slot tracker and hold the results it owes, oldest first.
  class region_scoreboard;
    bit               enable;
    int               left_b, top_b, right_b, bottom_b;
    logic [4:0]       cur_slot;
    int               slot_x[SLOT_COUNT];
    int               slot_y[SLOT_COUNT];
    id_class_t        slot_cls[SLOT_COUNT];
    logic [MAP_W-1:0] active;
    bit               level;
    tir_res_t         owed_results[$];
    int               errors;

    function new();
      enable   = 0;
      left_b   = 0;
      top_b    = 0;
      right_b  = 0;
      bottom_b = 0;
      cur_slot = '0;
      active   = '0;
      level    = 0;
      errors   = 0;
      foreach (slot_x[i]) begin
        slot_x[i]   = 0;
        slot_y[i]   = 0;
        slot_cls[i] = CLS_OTHER;
      end
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_ENABLE: enable   = data[0];
        REG_LEFT:   left_b   = $signed(data);
        REG_TOP:    top_b    = $signed(data);
        REG_RIGHT:  right_b  = $signed(data);
        REG_BOTTOM: bottom_b = $signed(data);
        default: ;
      endcase
    endfunction

    function void note_request(logic [TYPE_W-1:0] ev_type, logic [CODE_W-1:0] ev_code,
                               logic signed [VALUE_W-1:0] ev_value);
      bit               prev_level;
      logic [MAP_W-1:0] slot_bit;
      tir_res_t         owed;
      prev_level = level;
      if (ev_type == TYPE_ABS) begin
        case (ev_code)
          CODE_SLOT:  if (ev_value >= 0 && ev_value < SLOT_COUNT) cur_slot = ev_value[4:0];
          CODE_X:     slot_x[cur_slot] = ev_value / COORD_SCALE;
          CODE_Y:     slot_y[cur_slot] = ev_value / COORD_SCALE;
          CODE_TRACK: begin
            if (ev_value == ID_LIFT) slot_cls[cur_slot] = CLS_NONE;
            else if (ev_value > 0)   slot_cls[cur_slot] = CLS_POS;
            else                     slot_cls[cur_slot] = CLS_OTHER;
          end
          default: ;
        endcase
      end
      // Tracking and sync codes evaluate the map whatever the event type.
      if (enable && (ev_code == CODE_TRACK || ev_code == CODE_SYNC)) begin
        slot_bit = 32'd1 << cur_slot;
        if (ev_code == CODE_TRACK) begin
          if (slot_cls[cur_slot] == CLS_NONE) active &= ~slot_bit;
        end else begin
          if (slot_cls[cur_slot] == CLS_POS) begin
            if (slot_x[cur_slot] > left_b && slot_x[cur_slot] < right_b &&
                slot_y[cur_slot] > top_b && slot_y[cur_slot] < bottom_b)
              active |= slot_bit;
            else
              active &= ~slot_bit;
          end
          level = (active != '0);
        end
      end
      owed.region_level  = level;
      owed.level_changed = (level != prev_level);
      owed.active_map    = active;
      owed_results.push_back(owed);
    endfunction

    function void check_result(logic lvl, logic chg, logic [MAP_W-1:0] map);
      tir_res_t want;
      if (owed_results.size() == 0) begin
        $error("stray result: region_level=%0d level_changed=%0d active_map=%h",
               lvl, chg, map);
        errors++;
        return;
      end
      want = owed_results.pop_front();
      if (lvl !== want.region_level) begin
        $error("region_level: expected %0d, got %0d", want.region_level, lvl);
        errors++;
      end
      if (chg !== want.level_changed) begin
        $error("level_changed: expected %0d, got %0d", want.level_changed, chg);
        errors++;
      end
      if (map !== want.active_map) begin
        $error("active_map: expected %h, got %h", want.active_map, map);
        errors++;
      end
    endfunction

    function int outstanding();
      return owed_results.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  tir_event_if  events_bus ();
  tir_result_if results_bus ();

  region_scoreboard board;

  // Rectangle in force, used to aim coordinates at its edges.
  int rect_left, rect_top, rect_right, rect_bottom;
  int sent_count  = 0;
  int burst_left  = 0;
  bit hold_off_req = 0;

  touch_in_region_slot_tracker DUT (
    .clk       (clk),
    .rst       (rst),
    .events    (events_bus),
    .results   (results_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 0;
  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #5_000_000;
    $display("touch_in_region_slot_tracker_test: FAIL");
    $finish;
  end

  // Note each accepted request in order; the predictor runs here.
  always @(posedge clk) begin
    if (!rst && events_bus.valid && events_bus.ready)
      board.note_request(events_bus.event_type, events_bus.event_code, events_bus.event_value);
  end

  // Check each accepted result against the oldest owed one.
  always @(posedge clk) begin
    if (!rst && results_bus.valid && results_bus.ready)
      board.check_result(results_bus.region_level, results_bus.level_changed,
                         results_bus.active_map);
  end

  // Result side: stall in styles picked at random run after run, and
  // hold off for a long stretch whenever the stimulus asks for it.
  initial begin
    int style;
    int run;
    int rx_cycle;
    style    = 0;
    run      = 0;
    rx_cycle = 0;
    results_bus.ready = 0;
    wait (rst === 1'b0);
    forever begin
      @(negedge clk);
      rx_cycle++;
      if (hold_off_req) begin
        // Hold ready low long enough for the block to fill and stall its input.
        results_bus.ready = 0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off_req = 0;
        results_bus.ready = 1;
      end else begin
        if (run == 0) begin
          style = $urandom_range(0, 3);
          run   = $urandom_range(20, 200);
        end
        run--;
        case (style)
          0: results_bus.ready = 1;
          1: results_bus.ready = ($urandom_range(0, 3) != 0);
          2: results_bus.ready = ($urandom_range(0, 1) == 1);
          default: results_bus.ready = ((rx_cycle % 7) > 2);
        endcase
      end
    end
  end

  // Between requests: stay in the burst, or drop valid for a random gap and
  // pick the next burst. Some bursts run long so stretches go without idling.
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 7);
      @(negedge clk);
      events_bus.valid = 0;
      repeat (gap - 1) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 15);
    end
  endtask

  // Offer one request at the falling edge and hold it until accepted.
  task automatic send_event(input logic [TYPE_W-1:0] ev_type, input logic [CODE_W-1:0] ev_code,
                            input logic signed [VALUE_W-1:0] ev_value);
    @(negedge clk);
    events_bus.valid       = 1;
    events_bus.event_type  = ev_type;
    events_bus.event_code  = ev_code;
    events_bus.event_value = ev_value;
    @(posedge clk);
    while (!events_bus.ready) @(posedge clk);
    sent_count++;
    pace();
  endtask

  // Drop valid and wait until every owed result has come back.
  task automatic quiesce();
    @(negedge clk);
    events_bus.valid = 0;
    while (board.outstanding() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
    @(negedge clk);
    cfg_we    = 1;
    cfg_index = idx;
    cfg_data  = data[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we = 0;
    board.write_reg(idx, data[CFG_DATA_W-1:0]);
  endtask

  // Write every register with the block idle; poke the spare indexes as well.
  task automatic apply_setting(input bit en, input int l, input int t, input int r,
                               input int b);
    quiesce();
    write_reg(REG_ENABLE, int'(en));
    write_reg(REG_LEFT, l);
    write_reg(REG_TOP, t);
    write_reg(REG_RIGHT, r);
    write_reg(REG_BOTTOM, b);
    write_reg(REG_SPARE_LO, $urandom);
    write_reg(REG_SPARE_HI, $urandom);
    rect_left   = l;
    rect_top    = t;
    rect_right  = r;
    rect_bottom = b;
  endtask

  // Raw coordinate whose scaled value lands on or near an edge, inside the
  // span, near zero, or anywhere. Remainders exercise the truncation.
  function automatic int pick_raw(input int lo, input int hi);
    longint target;
    longint raw;
    case ($urandom_range(0, 5))
      0: target = longint'(lo) + longint'($urandom_range(0, 2)) - 1;
      1: target = longint'(hi) + longint'($urandom_range(0, 2)) - 1;
      2: begin
        if (hi > lo) target = longint'(lo) + longint'($urandom_range(0, hi - lo));
        else target = longint'(lo);
      end
      3: return $urandom;
      4: target = longint'($urandom_range(0, 200)) - 100;
      default: return ($urandom_range(0, 1)) ? 32'h7fff_ffff : 32'h8000_0000;
    endcase
    if (target >= 0) raw = target * COORD_SCALE + longint'($urandom_range(0, 99));
    else raw = target * COORD_SCALE - longint'($urandom_range(0, 99));
    if (raw > 64'sd2147483647) raw = 64'sd2147483647;
    if (raw < -64'sd2147483648) raw = -64'sd2147483648;
    return int'(raw);
  endfunction

  // Mostly live ids, some lifts, some zero or other negative ids.
  function automatic int pick_id();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll < 14) return int'($urandom_range(1, 32'h7fff_ffff));
    if (roll < 17) return ID_LIFT;
    if (roll == 17) return 0;
    if (roll == 18) return -int'($urandom_range(2, 32'h7fff_ffff));
    return $urandom;
  endfunction

  // One report: a few touches, each with slot, id and position, then a sync.
  // Pieces drop out now and then so broken reports are covered too.
  task automatic touch_frame();
    int touches;
    int slot_no;
    touches = $urandom_range(1, 3);
    repeat (touches) begin
      slot_no = ($urandom_range(0, 3) == 0) ? $urandom_range(0, SLOT_COUNT - 1)
                                            : $urandom_range(0, 5);
      if ($urandom_range(0, 9) != 0) send_event(TYPE_ABS, CODE_SLOT, slot_no);
      if ($urandom_range(0, 7) != 0) send_event(TYPE_ABS, CODE_TRACK, pick_id());
      if ($urandom_range(0, 9) != 0) send_event(TYPE_ABS, CODE_X, pick_raw(rect_left, rect_right));
      if ($urandom_range(0, 9) != 0) send_event(TYPE_ABS, CODE_Y, pick_raw(rect_top, rect_bottom));
    end
    send_event(TYPE_SYN_EVENT, CODE_SYNC, ($urandom_range(0, 7) == 0) ? $urandom : 0);
  endtask

  // Stray requests: random everything, bad slots, tracking and sync codes
  // under foreign types, unknown codes.
  task automatic noise_event();
    case ($urandom_range(0, 4))
      0: send_event(TYPE_W'($urandom_range(0, 31)), CODE_W'($urandom_range(0, 1023)), $urandom);
      1: send_event(TYPE_ABS, CODE_SLOT, ($urandom_range(0, 1)) ?
                    int'($urandom_range(SLOT_COUNT, 32'h7fff_ffff)) :
                    -int'($urandom_range(1, 32'h7fff_ffff)));
      2: send_event(TYPE_W'($urandom_range(0, 31)),
                    ($urandom_range(0, 1)) ? CODE_TRACK : CODE_SYNC, $urandom);
      3: send_event(TYPE_ABS, CODE_W'($urandom_range(0, 1023)), $urandom);
      default: send_event(TYPE_ABS, ($urandom_range(0, 1)) ? CODE_X : CODE_Y, $urandom);
    endcase
  endtask

  initial begin
    int phase;
    int base_count;
    int l, t;
    board = new();
    events_bus.valid       = 0;
    events_bus.event_type  = '0;
    events_bus.event_code  = '0;
    events_bus.event_value = '0;
    cfg_we    = 0;
    cfg_index = REG_ENABLE;
    cfg_data  = '0;
    rst = 1;
    repeat (11) @(negedge clk);
    rst = 0;

    // Directed part: small square around the origin.
    apply_setting(1, -50, -50, 50, 50);
    // Out-of-range slots are ignored; then take the top slot.
    send_event(TYPE_ABS, CODE_SLOT, -1);
    send_event(TYPE_ABS, CODE_SLOT, SLOT_COUNT);
    send_event(TYPE_ABS, CODE_SLOT, 32'h7fff_ffff);
    send_event(TYPE_ABS, CODE_SLOT, SLOT_COUNT - 1);
    // A touch inside on slot 31: the map goes negative as a signed word.
    send_event(TYPE_ABS, CODE_TRACK, 5);
    send_event(TYPE_ABS, CODE_X, 1000);
    send_event(TYPE_ABS, CODE_Y, -2599);
    send_event(TYPE_SYN_EVENT, CODE_SYNC, 0);
    // Slot 0 at the extreme raw values: outside.
    send_event(TYPE_ABS, CODE_SLOT, 0);
    send_event(TYPE_ABS, CODE_TRACK, 32'h7fff_ffff);
    send_event(TYPE_ABS, CODE_X, 32'h8000_0000);
    send_event(TYPE_ABS, CODE_Y, 32'h7fff_ffff);
    send_event(TYPE_SYN_EVENT, CODE_SYNC, 32'hffff_ffff);
    // Just inside, with a sync that carries the axis type.
    send_event(TYPE_ABS, CODE_X, 4999);
    send_event(TYPE_ABS, CODE_Y, -4999);
    send_event(TYPE_ABS, CODE_SYNC, 7);
    // On the right edge counts as outside.
    send_event(TYPE_ABS, CODE_X, 5000);
    send_event(TYPE_SYN_EVENT, CODE_SYNC, 0);
    // Lift under a foreign type: the id stays, evaluation still runs.
    send_event(5'h1f, CODE_TRACK, ID_LIFT);
    // Lift both touches; the level falls at the sync.
    send_event(TYPE_ABS, CODE_TRACK, ID_LIFT);
    send_event(TYPE_ABS, CODE_SLOT, SLOT_COUNT - 1);
    send_event(TYPE_ABS, CODE_TRACK, ID_LIFT);
    send_event(TYPE_SYN_EVENT, CODE_SYNC, 0);
    // Id zero and a fully foreign request.
    send_event(TYPE_ABS, CODE_TRACK, 0);
    send_event(5'h1f, 10'h3ff, 32'h8000_0000);

    // Random part, one rectangle per phase.
    base_count = sent_count;
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: apply_setting(1, -50, -50, 50, 50);
        1: apply_setting(1, -BOUND_LIMIT, -BOUND_LIMIT, BOUND_LIMIT, BOUND_LIMIT);
        2: apply_setting(1, 0, 0, 0, 0);
        3: apply_setting(0, -100, -100, 100, 100);
        4: apply_setting(1, BOUND_LIMIT, BOUND_LIMIT, -BOUND_LIMIT, -BOUND_LIMIT);
        5: apply_setting(1, FIELD_MIN, FIELD_MIN, FIELD_MAX, FIELD_MAX);
        6: begin
          l = -int'($urandom_range(0, 30000));
          t = -int'($urandom_range(0, 30000));
          apply_setting(1, l, t, l + int'($urandom_range(1, 60000)),
                        t + int'($urandom_range(1, 60000)));
        end
        default: apply_setting(1, -1, -1, 1, 1);
      endcase
      // Starve the result side while requests keep coming.
      if (phase == 1 || phase == 5) hold_off_req = 1;
      while (sent_count < base_count + (phase + 1) * (RANDOM_ITEMS / PHASES)) begin
        if ($urandom_range(0, 5) == 0) noise_event();
        else touch_frame();
      end
    end

    quiesce();
    // Let any stray result show up before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.outstanding() == 0) begin
      $display("touch_in_region_slot_tracker_test: PASS");
    end else begin
      $display("touch_in_region_slot_tracker_test: FAIL");
    end
    $finish;
  end

endmodule
